### src/tra_pkg.sv
`timescale 1ns / 1ps

package tra_pkg;

    localparam int PROG_DEPTH_DEF = 256;
    localparam int RAM_DEPTH_DEF  = 1024;
    localparam int FRAC_BITS_DEF  = 32;

    // Width of a limit handed to the address range check (up to 4096 + 1).
    localparam int LIM_W   = 13;
    localparam int EPOCH_W = 8;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    localparam logic [1:0] OPN_LOAD  = 2'd0;
    localparam logic [1:0] OPN_START = 2'd1;
    localparam logic [1:0] OPN_STEP  = 2'd2;

    localparam logic [1:0] RS_A = 2'd1;
    localparam logic [1:0] RS_B = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PRINT = 2'd1;
    localparam logic [1:0] ST_HALT  = 2'd2;
    localparam logic [1:0] ST_FAULT = 2'd3;

    typedef enum logic [3:0] {
        OP_LOAD        = 4'd0,
        OP_STORE       = 4'd1,
        OP_SET         = 4'd2,
        OP_SWAP        = 4'd3,
        OP_ADD         = 4'd4,
        OP_SUB         = 4'd5,
        OP_MUL         = 4'd6,
        OP_DIV         = 4'd7,
        OP_MOD         = 4'd8,
        OP_EQUAL       = 4'd9,
        OP_NOT         = 4'd10,
        OP_GOTO        = 4'd11,
        OP_GOTO_IF     = 4'd12,
        OP_GOTO_IF_NOT = 4'd13,
        OP_EXIT        = 4'd14,
        OP_PRINT       = 4'd15
    } opcode_t;

    typedef enum logic [1:0] {
        MD_MUL = 2'd0,
        MD_DIV = 2'd1,
        MD_MOD = 2'd2
    } md_kind_t;

    typedef struct packed {
        logic     start;
        md_kind_t kind;
    } md_req_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  instr_index;
        logic [3:0]  opcode;
        logic [1:0]  reg_select;
        logic        has_arg;
        logic [63:0] arg_value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] value;
        logic [8:0]  next_pc;
    } out_word_t;

    typedef struct packed {
        logic        has_arg;
        logic [1:0]  reg_select;
        opcode_t     opcode;
        logic [63:0] arg_value;
    } prog_word_t;

endpackage

### src/tra_ram.sv
`timescale 1ns / 1ps

module tra_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

### src/tra_muldiv.sv
`timescale 1ns / 1ps

module tra_muldiv import tra_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  md_req_t     req,
    input  logic [63:0] x,
    input  logic [63:0] y,
    output logic        done,
    output logic [63:0] result
);

    localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAXPOS = 64'h7FFF_FFFF_FFFF_FFFF;

    logic         busy_reg;
    logic         done_reg;
    md_kind_t     kind_reg;
    logic         neg_reg;
    logic [6:0]   cnt_reg;
    logic [127:0] acc_reg;
    logic [64:0]  rem_reg;
    logic [63:0]  q_reg;
    logic         ovf_reg;
    logic [63:0]  xmag_reg;
    logic [63:0]  ymag_reg;

    logic [63:0] xm, ym;
    logic [64:0] sum;
    logic [64:0] r2;
    logic        ge;

    function automatic logic [63:0] sat(input logic neg, input logic [63:0] mag,
                                        input logic over);
        if (neg) begin
            return (over || mag > SIGN64) ? SIGN64 : (64'd0 - mag);
        end
        return (over || mag[63]) ? MAXPOS : mag;
    endfunction

    assign xm  = x[63] ? (64'd0 - x) : x;
    assign ym  = y[63] ? (64'd0 - y) : y;
    assign sum = {1'b0, acc_reg[127:64]} + (acc_reg[0] ? {1'b0, xmag_reg} : 65'd0);
    assign r2  = {rem_reg[63:0], acc_reg[127]};
    assign ge  = r2 >= {1'b0, ymag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                kind_reg <= req.kind;
                xmag_reg <= xm;
                ymag_reg <= ym;
                rem_reg  <= '0;
                q_reg    <= '0;
                ovf_reg  <= 1'b0;
                case (req.kind)
                    MD_MUL: begin
                        neg_reg <= x[63] ^ y[63];
                        acc_reg <= {64'd0, ym};
                        cnt_reg <= 7'd63;
                    end
                    MD_DIV: begin
                        neg_reg <= x[63] ^ y[63];
                        acc_reg <= {64'd0, xm} << FRAC_BITS;
                        cnt_reg <= 7'd127;
                    end
                    default: begin
                        neg_reg <= x[63];
                        acc_reg <= {64'd0, xm};
                        cnt_reg <= 7'd127;
                    end
                endcase
            end else if (busy_reg) begin
                if (kind_reg == MD_MUL) begin
                    // Shift-add: the product grows in from the top of the accumulator.
                    acc_reg <= {sum, acc_reg[63:1]};
                end else begin
                    acc_reg <= {acc_reg[126:0], 1'b0};
                    rem_reg <= ge ? (r2 - {1'b0, ymag_reg}) : r2;
                    q_reg   <= {q_reg[62:0], ge};
                    ovf_reg <= ovf_reg | q_reg[63];
                end
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        case (kind_reg)
            MD_MUL:  result = sat(neg_reg, acc_reg[63+FRAC_BITS:FRAC_BITS],
                                  |acc_reg[127:64+FRAC_BITS]);
            MD_DIV:  result = sat(neg_reg, q_reg, ovf_reg);
            default: result = neg_reg ? (64'd0 - rem_reg[63:0]) : rem_reg[63:0];
        endcase
    end

    assign done = done_reg;

endmodule

### src/two_register_accumulator_core.sv
`timescale 1ns / 1ps

// Two-register fixed point machine with program memory and data RAM.
// Input words arrive on s_valid/s_ready/s_data: load an instruction into a
// program slot, start a run, or execute one step. Every input word yields
// exactly one result word on m_valid/m_ready/m_data (status, value, next_pc).
// program_length is to be written through cfg_we/cfg_wdata only while the block
// is idle; the block itself does not enforce this. Load, start and ignored
// words, and a step that halts or faults before fetch, go from dispatch
// straight to the result; other steps pass through fetch and execute, then a
// RAM load or print reads the data RAM, while multiply, divide and modulo wait
// on the one-bit-per-cycle multiply/divide unit. One word is in flight at a
// time; s_ready is high only when idle. The data RAM holds an epoch tag per
// word; a start bumps the epoch so older words read as zero. After reset, and
// on every 255th start, the block sweeps the data RAM while s_ready stays low.
// The result sits in an output register: a stalled receiver holds that word
// while the next input word is accepted and processed; the block then waits
// until the register frees before it presents the next result.
module two_register_accumulator_core import tra_pkg::*; #(
    parameter int PROG_DEPTH = PROG_DEPTH_DEF,
    parameter int RAM_DEPTH  = RAM_DEPTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [8:0] cfg_wdata,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int PAW = $clog2(PROG_DEPTH);
    localparam int DAW = $clog2(RAM_DEPTH);
    localparam int IPW = 64 - FRAC_BITS;
    localparam int PW  = $bits(prog_word_t);
    localparam int DW  = EPOCH_W + 64;

    typedef enum logic [7:0] {
        S_SWEEP    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_DISPATCH = 8'b0000_0100,
        S_FETCH    = 8'b0000_1000,
        S_EXEC     = 8'b0001_0000,
        S_MEMRD    = 8'b0010_0000,
        S_MULDIV   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    typedef enum logic [1:0] {
        RUN_IDLE  = 2'd0,
        RUN_BUSY  = 2'd1,
        RUN_HALT  = 2'd2,
        RUN_FAULT = 2'd3
    } run_t;

    state_t           state_reg;
    run_t             run_reg;
    logic [8:0]       len_cfg_reg;
    logic [8:0]       pc_reg;
    logic [63:0]      a_reg, b_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [DAW-1:0]   sweep_cnt_reg;
    logic             sweep_done_reg;
    in_word_t         in_reg;
    prog_word_t       ir_reg;
    logic [1:0]       status_reg;
    logic [63:0]      value_reg;
    logic             m_valid_reg;
    out_word_t        m_data_reg;

    logic [8:0]       len;
    logic [PAW-1:0]   prog_addr;
    logic             prog_we;
    logic [PW-1:0]    prog_rdata;
    logic [DAW-1:0]   data_addr;
    logic             data_we;
    logic [DW-1:0]    data_wdata, data_rdata;
    logic [63:0]      mem_val;

    opcode_t          op;
    logic             has, tgt_ok, needs_reg, needs_arg, take, fault;
    logic             addr_ok, jmp_ok;
    logic [63:0]      tgt_val, x_op, y_op, sum_v, dif_v, alu_v;
    logic [IPW-1:0]   ip_v;
    md_req_t          md_req;
    logic             md_done;
    logic [63:0]      md_result;

    function automatic logic ip_ok(input logic [63:0] v, input logic [LIM_W-1:0] lim);
        if (v[63]) begin
            return (&v[63:FRAC_BITS]) && (|v[FRAC_BITS-1:0]);
        end
        return v[63:FRAC_BITS] < IPW'(lim);
    endfunction

    assign len = (len_cfg_reg < PROG_DEPTH) ? len_cfg_reg : 9'(PROG_DEPTH);

    // Decode of the fetched instruction.
    assign op        = ir_reg.opcode;
    assign has       = ir_reg.has_arg;
    assign tgt_ok    = (ir_reg.reg_select == RS_A) || (ir_reg.reg_select == RS_B);
    assign tgt_val   = (ir_reg.reg_select == RS_B) ? b_reg : a_reg;
    assign needs_reg = !(op == OP_SWAP || op == OP_GOTO || op == OP_EXIT ||
                         (op == OP_PRINT && has));
    assign needs_arg = (op == OP_LOAD) || (op == OP_STORE) || (op == OP_SET) ||
                       (op == OP_GOTO) || (op == OP_GOTO_IF) || (op == OP_GOTO_IF_NOT);
    assign x_op      = has ? tgt_val : a_reg;
    assign y_op      = has ? ir_reg.arg_value : b_reg;
    assign ip_v      = ir_reg.arg_value[63] ? '0 : ir_reg.arg_value[63:FRAC_BITS];
    assign addr_ok   = ip_ok(ir_reg.arg_value, LIM_W'(RAM_DEPTH));
    assign jmp_ok    = ip_ok(ir_reg.arg_value, LIM_W'(len) + LIM_W'(1));
    assign take      = (op == OP_GOTO) || (op == OP_GOTO_IF && tgt_val != '0) ||
                       (op == OP_GOTO_IF_NOT && tgt_val == '0);

    always_comb begin
        fault = (needs_reg && !tgt_ok) || (needs_arg && !has);
        if ((op == OP_DIV || op == OP_MOD) && y_op == '0) begin
            fault = 1'b1;
        end
        if ((op == OP_LOAD || op == OP_STORE || (op == OP_PRINT && has)) && !addr_ok) begin
            fault = 1'b1;
        end
        if ((op == OP_GOTO || op == OP_GOTO_IF || op == OP_GOTO_IF_NOT) && take && !jmp_ok)
        begin
            fault = 1'b1;
        end
    end

    assign sum_v = x_op + y_op;
    assign dif_v = x_op - y_op;

    always_comb begin
        case (op)
            OP_ADD: begin
                if (x_op[63] == y_op[63] && sum_v[63] != x_op[63]) begin
                    alu_v = x_op[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                end else begin
                    alu_v = sum_v;
                end
            end
            OP_SUB: begin
                if (x_op[63] != y_op[63] && dif_v[63] != x_op[63]) begin
                    alu_v = x_op[63] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
                end else begin
                    alu_v = dif_v;
                end
            end
            OP_EQUAL: alu_v = (x_op == y_op) ? (64'd1 << FRAC_BITS) : '0;
            OP_NOT:   alu_v = (tgt_val == '0) ? (64'd1 << FRAC_BITS) : '0;
            default:  alu_v = ir_reg.arg_value;
        endcase
    end

    // Memory port control.
    assign prog_we   = (state_reg == S_DISPATCH) && (in_reg.operation == OPN_LOAD) &&
                       (in_reg.instr_index < PROG_DEPTH);
    assign prog_addr = (state_reg == S_DISPATCH && in_reg.operation == OPN_LOAD)
                       ? PAW'(in_reg.instr_index) : PAW'(pc_reg);

    assign data_addr  = (state_reg == S_SWEEP) ? sweep_cnt_reg : ip_v[DAW-1:0];
    assign data_we    = (state_reg == S_SWEEP) ||
                        (state_reg == S_EXEC && !fault && op == OP_STORE);
    assign data_wdata = (state_reg == S_SWEEP) ? '0 : {epoch_reg, tgt_val};
    assign mem_val    = (data_rdata[DW-1:64] == epoch_reg) ? data_rdata[63:0] : '0;

    always_comb begin
        md_req.start = (state_reg == S_EXEC) && !fault &&
                       (op == OP_MUL || op == OP_DIV || op == OP_MOD);
        case (op)
            OP_MUL:  md_req.kind = MD_MUL;
            OP_DIV:  md_req.kind = MD_DIV;
            default: md_req.kind = MD_MOD;
        endcase
    end

    tra_ram #(.WIDTH(PW), .DEPTH(PROG_DEPTH)) u_prog_ram (
        .aclk  (aclk),
        .we    (prog_we),
        .addr  (prog_addr),
        .wdata ({in_reg.has_arg, in_reg.reg_select, in_reg.opcode, in_reg.arg_value}),
        .rdata (prog_rdata)
    );

    tra_ram #(.WIDTH(DW), .DEPTH(RAM_DEPTH)) u_data_ram (
        .aclk  (aclk),
        .we    (data_we),
        .addr  (data_addr),
        .wdata (data_wdata),
        .rdata (data_rdata)
    );

    tra_muldiv #(.FRAC_BITS(FRAC_BITS)) u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .x       (x_op),
        .y       (y_op),
        .done    (md_done),
        .result  (md_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_SWEEP;
            run_reg        <= RUN_IDLE;
            len_cfg_reg    <= '0;
            pc_reg         <= '0;
            a_reg          <= '0;
            b_reg          <= '0;
            epoch_reg      <= '0;
            sweep_cnt_reg  <= '0;
            sweep_done_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                len_cfg_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_SWEEP: begin
                    sweep_cnt_reg <= sweep_cnt_reg + DAW'(1);
                    if (sweep_cnt_reg == DAW'(RAM_DEPTH - 1)) begin
                        epoch_reg <= EPOCH_W'(1);
                        state_reg <= sweep_done_reg ? S_DONE : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid) begin
                        in_reg    <= s_data;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    status_reg <= ST_OK;
                    value_reg  <= '0;
                    state_reg  <= S_DONE;
                    unique case (in_reg.operation)
                        OPN_START: begin
                            a_reg   <= '0;
                            b_reg   <= '0;
                            pc_reg  <= '0;
                            run_reg <= RUN_BUSY;
                            if (epoch_reg == EPOCH_MAX) begin
                                // Tags would repeat: wipe the RAM and restart at one.
                                sweep_cnt_reg  <= '0;
                                sweep_done_reg <= 1'b1;
                                state_reg      <= S_SWEEP;
                            end else begin
                                epoch_reg <= epoch_reg + EPOCH_W'(1);
                            end
                        end
                        OPN_STEP: begin
                            if (run_reg != RUN_BUSY) begin
                                status_reg <= ST_FAULT;
                            end else if (pc_reg >= len) begin
                                status_reg <= ST_HALT;
                                value_reg  <= a_reg;
                                run_reg    <= RUN_HALT;
                            end else begin
                                state_reg <= S_FETCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_FETCH: begin
                    ir_reg    <= prog_word_t'(prog_rdata);
                    state_reg <= S_EXEC;
                end
                S_EXEC: begin
                    state_reg <= S_DONE;
                    if (fault) begin
                        status_reg <= ST_FAULT;
                        value_reg  <= '0;
                        run_reg    <= RUN_FAULT;
                    end else begin
                        pc_reg <= pc_reg + 9'd1;
                        case (op)
                            OP_LOAD: begin
                                pc_reg    <= pc_reg;
                                state_reg <= S_MEMRD;
                            end
                            OP_PRINT: begin
                                if (has) begin
                                    pc_reg    <= pc_reg;
                                    state_reg <= S_MEMRD;
                                end else begin
                                    status_reg <= ST_PRINT;
                                    value_reg  <= tgt_val;
                                end
                            end
                            OP_STORE: begin
                            end
                            OP_SWAP: begin
                                a_reg <= b_reg;
                                b_reg <= a_reg;
                            end
                            OP_MUL, OP_DIV, OP_MOD: begin
                                pc_reg    <= pc_reg;
                                state_reg <= S_MULDIV;
                            end
                            OP_GOTO, OP_GOTO_IF, OP_GOTO_IF_NOT: begin
                                if (take) begin
                                    pc_reg <= ip_v[8:0];
                                end
                            end
                            OP_EXIT: begin
                                pc_reg     <= pc_reg;
                                status_reg <= ST_HALT;
                                value_reg  <= a_reg;
                                run_reg    <= RUN_HALT;
                            end
                            default: begin
                                // SET and the ALU ops: ADD, SUB, EQUAL and NOT.
                                if (ir_reg.reg_select == RS_B) begin
                                    b_reg <= alu_v;
                                end else begin
                                    a_reg <= alu_v;
                                end
                            end
                        endcase
                    end
                end
                S_MEMRD: begin
                    pc_reg    <= pc_reg + 9'd1;
                    state_reg <= S_DONE;
                    if (op == OP_LOAD) begin
                        if (ir_reg.reg_select == RS_B) begin
                            b_reg <= mem_val;
                        end else begin
                            a_reg <= mem_val;
                        end
                    end else begin
                        status_reg <= ST_PRINT;
                        value_reg  <= mem_val;
                    end
                end
                S_MULDIV: begin
                    if (md_done) begin
                        pc_reg    <= pc_reg + 9'd1;
                        state_reg <= S_DONE;
                        if (ir_reg.reg_select == RS_B) begin
                            b_reg <= md_result;
                        end else begin
                            a_reg <= md_result;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_data_reg.status  <= status_reg;
                        m_data_reg.value   <= value_reg;
                        m_data_reg.next_pc <= pc_reg;
                        sweep_done_reg     <= 1'b0;
                        state_reg          <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### src/tra_checker.sv
`timescale 1ns / 1ps

module tra_props import tra_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      cfg_we,
    input logic [8:0] cfg_wdata,
    input logic      s_valid,
    input logic      s_ready,
    input in_word_t  s_data,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // A word held back by the receiver must not change.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed while stalled");

    // Only one input word is worked on at a time.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted while busy");

    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_FAULT |-> m_data.value == 64'd0)
        else $error("fault result carries a value");

    a_ok_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status == ST_OK |-> m_data.value == 64'd0)
        else $error("plain result carries a value");

endmodule

bind two_register_accumulator_core tra_props u_tra_props (.*);

### bench/tra_checker.sv
`timescale 1ns / 1ps

module tra_checker import tra_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      cfg_we,
    input  logic [8:0] cfg_wdata,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        errors,
    output int        pending
);

    typedef enum logic [1:0] {
        RUN_IDLE    = 2'd0,
        RUN_ACTIVE  = 2'd1,
        RUN_HALTED  = 2'd2,
        RUN_FAULTED = 2'd3
    } run_state_t;

    localparam logic [63:0] SIGN_FX = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MAX_FX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ONE_FX  = 64'h0000_0001_0000_0000;

    prog_word_t  prog_mem [PROG_DEPTH_DEF];
    logic [63:0] ram_word [RAM_DEPTH_DEF];
    bit          ram_set  [RAM_DEPTH_DEF];
    logic [63:0] acc_a, acc_b;
    int          pc;
    run_state_t  run_state;
    int          prog_len;
    out_word_t   expected_words [$];

    assign pending = expected_words.size();

    function automatic logic [63:0] mag_of(logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] clamp(bit neg, logic [63:0] mag, bit over);
        if (neg) return (over || mag > SIGN_FX) ? SIGN_FX : -mag;
        return (over || mag > MAX_FX) ? MAX_FX : mag;
    endfunction

    function automatic logic [63:0] sat_add(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        r = x + y;
        if (x[63] == y[63] && r[63] != x[63]) return x[63] ? SIGN_FX : MAX_FX;
        return r;
    endfunction

    function automatic logic [63:0] sat_sub(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        r = x - y;
        if (x[63] != y[63] && r[63] != x[63]) return x[63] ? SIGN_FX : MAX_FX;
        return r;
    endfunction

    function automatic logic [63:0] fx_product(logic [63:0] x, logic [63:0] y);
        logic [127:0] p;
        p = {64'b0, mag_of(x)} * {64'b0, mag_of(y)};
        return clamp(x[63] ^ y[63], p[95:32], p[127:96] != 0);
    endfunction

    function automatic logic [63:0] fx_quotient(logic [63:0] x, logic [63:0] y);
        logic [127:0] q;
        q = {32'b0, mag_of(x), 32'b0} / {64'b0, mag_of(y)};
        return clamp(x[63] ^ y[63], q[63:0], q[127:64] != 0);
    endfunction

    function automatic logic [63:0] fx_remainder(logic [63:0] x, logic [63:0] y);
        logic [63:0] r;
        r = mag_of(x) % mag_of(y);
        return x[63] ? -r : r;
    endfunction

    // Integer part truncated toward zero, checked against [0, lim).
    function automatic bit index_of(logic [63:0] v, int lim, output int ip);
        logic [63:0] whole;
        ip = 0;
        if (v[63]) begin
            if (-v >= ONE_FX) return 0;
            whole = 0;
        end else begin
            whole = v >> 32;
        end
        if (whole >= lim) return 0;
        ip = int'(whole);
        return 1;
    endfunction

    function automatic out_word_t execute_word(in_word_t w);
        out_word_t   res;
        prog_word_t  pw;
        opcode_t     op;
        logic [63:0] cur, x, y, nv, arg;
        bit          fault, wr, needs_reg, needs_arg, tgt_ok, take;
        int          nxt, idx, len;
        res = '0;
        len = (prog_len < PROG_DEPTH_DEF) ? prog_len : PROG_DEPTH_DEF;
        if (w.operation == OPN_LOAD) begin
            prog_mem[w.instr_index] = {w.has_arg, w.reg_select, opcode_t'(w.opcode),
                                       w.arg_value};
        end else if (w.operation == OPN_START) begin
            acc_a = 0;
            acc_b = 0;
            foreach (ram_set[i]) ram_set[i] = 0;
            pc = 0;
            run_state = RUN_ACTIVE;
        end else if (w.operation == OPN_STEP) begin
            if (run_state != RUN_ACTIVE) begin
                res.status = ST_FAULT;
            end else if (pc >= len) begin
                res.status = ST_HALT;
                res.value = acc_a;
                run_state = RUN_HALTED;
            end else begin
                pw = prog_mem[pc];
                op = pw.opcode;
                arg = pw.arg_value;
                tgt_ok = pw.reg_select == RS_A || pw.reg_select == RS_B;
                cur = (pw.reg_select == RS_A) ? acc_a : acc_b;
                needs_reg = !(op == OP_SWAP || op == OP_GOTO || op == OP_EXIT ||
                              (op == OP_PRINT && pw.has_arg));
                needs_arg = op <= OP_SET || (op >= OP_GOTO && op <= OP_GOTO_IF_NOT);
                fault = (needs_reg && !tgt_ok) || (needs_arg && !pw.has_arg);
                x = pw.has_arg ? cur : acc_a;
                y = pw.has_arg ? arg : acc_b;
                if (!fault && (op == OP_DIV || op == OP_MOD) && y == 0) fault = 1;
                nxt = pc + 1;
                wr = 0;
                nv = 0;
                idx = 0;
                if (!fault) begin
                    case (op)
                        OP_LOAD: begin
                            if (!index_of(arg, RAM_DEPTH_DEF, idx)) fault = 1;
                            else begin
                                nv = ram_set[idx] ? ram_word[idx] : 64'd0;
                                wr = 1;
                            end
                        end
                        OP_STORE: begin
                            if (!index_of(arg, RAM_DEPTH_DEF, idx)) fault = 1;
                            else begin
                                ram_word[idx] = cur;
                                ram_set[idx] = 1;
                            end
                        end
                        OP_SET:   begin nv = arg; wr = 1; end
                        OP_SWAP:  begin nv = acc_a; acc_a = acc_b; acc_b = nv; end
                        OP_ADD:   begin nv = sat_add(x, y); wr = 1; end
                        OP_SUB:   begin nv = sat_sub(x, y); wr = 1; end
                        OP_MUL:   begin nv = fx_product(x, y); wr = 1; end
                        OP_DIV:   begin nv = fx_quotient(x, y); wr = 1; end
                        OP_MOD:   begin nv = fx_remainder(x, y); wr = 1; end
                        OP_EQUAL: begin nv = (x == y) ? ONE_FX : 64'd0; wr = 1; end
                        OP_NOT:   begin nv = (cur == 0) ? ONE_FX : 64'd0; wr = 1; end
                        OP_GOTO, OP_GOTO_IF, OP_GOTO_IF_NOT: begin
                            take = op == OP_GOTO || (op == OP_GOTO_IF && cur != 0) ||
                                   (op == OP_GOTO_IF_NOT && cur == 0);
                            if (take) begin
                                if (!index_of(arg, len + 1, idx)) fault = 1;
                                else nxt = idx;
                            end
                        end
                        OP_EXIT: begin
                            res.status = ST_HALT;
                            res.value = acc_a;
                            run_state = RUN_HALTED;
                            nxt = pc;
                        end
                        default: begin
                            if (pw.has_arg) begin
                                if (!index_of(arg, RAM_DEPTH_DEF, idx)) fault = 1;
                                else res.value = ram_set[idx] ? ram_word[idx] : 64'd0;
                            end else begin
                                res.value = cur;
                            end
                            res.status = ST_PRINT;
                        end
                    endcase
                end
                if (fault) begin
                    res.status = ST_FAULT;
                    res.value = 0;
                    run_state = RUN_FAULTED;
                end else begin
                    pc = nxt;
                    if (wr) begin
                        if (pw.reg_select == RS_A) acc_a = nv;
                        else acc_b = nv;
                    end
                end
            end
        end
        res.next_pc = pc[8:0];
        return res;
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (!aresetn) begin
            acc_a = 0;
            acc_b = 0;
            pc = 0;
            run_state = RUN_IDLE;
            prog_len = 0;
            foreach (ram_set[i]) ram_set[i] = 0;
            expected_words.delete();
            errors <= 0;
        end else begin
            if (cfg_we) prog_len = cfg_wdata;
            if (s_valid && s_ready) expected_words.push_back(execute_word(s_data));
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    if (errors < 10) $display("unexpected result word %p", m_data);
                    errors <= errors + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (m_data.status !== want.status || m_data.value !== want.value ||
                        m_data.next_pc !== want.next_pc) begin
                        if (errors < 10)
                            $display("mismatch: expected st=%0d val=%h pc=%0d, got st=%0d val=%h pc=%0d",
                                     want.status, want.value, want.next_pc,
                                     m_data.status, m_data.value, m_data.next_pc);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

### bench/tb_two_register_accumulator_core.sv
`timescale 1ns / 1ps

module tb_two_register_accumulator_core;
    import tra_pkg::*;

    localparam logic [1:0] OPN_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_WAIT  = 200;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic [8:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;
    int        errors, pending;

    int gap_pct, stall_pct;
    int hold_tickets;
    int words_sent;
    bit slot_loaded [PROG_DEPTH_DEF];

    two_register_accumulator_core uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    tra_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .errors(errors), .pending(pending)
    );

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever a ticket is raised.
    initial begin
        int hold_seen, hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_ready = 0;
        forever begin
            @(posedge aclk);
            if (hold_tickets > hold_seen) begin
                hold_seen++;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 0;
            end else begin
                m_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_word(in_word_t w);
        int gap;
        gap = 0;
        if ($urandom_range(99) < gap_pct) gap = $urandom_range(1, 4);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_data <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        if (w.operation == OPN_LOAD) slot_loaded[w.instr_index] = 1;
    endtask

    function automatic in_word_t mk_word(logic [1:0] opn, int slot, opcode_t op,
                                         logic [1:0] rs, bit has, logic [63:0] arg);
        in_word_t w;
        w.operation = opn;
        w.instr_index = slot[7:0];
        w.opcode = op;
        w.reg_select = rs;
        w.has_arg = has;
        w.arg_value = arg;
        return w;
    endfunction

    function automatic logic [63:0] fx_int(int n);
        return {32'(n), 32'($urandom_range(3) == 0 ? $urandom : 0)};
    endfunction

    function automatic in_word_t rand_instr(int slot, int len);
        opcode_t     op;
        logic [1:0]  rs;
        bit          has;
        logic [63:0] arg;
        int          pick;
        op = opcode_t'($urandom_range(15));
        rs = ($urandom_range(19) == 0) ? (($urandom_range(1) == 1) ? 2'd3 : 2'd0)
                                        : 2'($urandom_range(1, 2));
        if (op <= OP_SET || (op >= OP_GOTO && op <= OP_GOTO_IF_NOT))
            has = $urandom_range(19) != 0;
        else
            has = 1'($urandom_range(1));
        pick = $urandom_range(19);
        if (op == OP_LOAD || op == OP_STORE || op == OP_PRINT) begin
            if (pick == 0) arg = fx_int(1023);
            else if (pick == 1) arg = fx_int(1024);
            else if (pick == 2) arg = {32'hFFFF_FFFF, 32'($urandom)};
            else if (pick == 3) arg = -fx_int($urandom_range(1, 5));
            else arg = fx_int($urandom_range(15));
        end else if (op >= OP_GOTO && op <= OP_GOTO_IF_NOT) begin
            if (pick == 0) arg = fx_int(len + 1);
            else if (pick == 1) arg = -fx_int(1);
            else arg = fx_int($urandom_range(len));
        end else begin
            if (pick == 0) arg = 64'h7FFF_FFFF_FFFF_FFFF;
            else if (pick == 1) arg = 64'h8000_0000_0000_0000;
            else if (pick == 2) arg = 0;
            else if (pick < 6) arg = {$urandom, $urandom};
            else arg = {32'($signed($urandom_range(40)) - 20), 32'($urandom)};
        end
        return mk_word(OPN_LOAD, slot, op, rs, has, arg);
    endfunction

    task automatic wait_drained();
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic set_length(int v);
        cfg_we <= 1;
        cfg_wdata <= 9'(v);
        @(posedge aclk);
        cfg_we <= 0;
    endtask

    task automatic noise_word(int len);
        int pick;
        pick = $urandom_range(2);
        if (pick == 0)
            send_word(mk_word(OPN_NONE, $urandom_range(255), opcode_t'($urandom_range(15)),
                              2'($urandom_range(3)), 1'($urandom_range(1)),
                              {$urandom, $urandom}));
        else if (pick == 1 && len > 0)
            send_word(rand_instr($urandom_range(len - 1), len));
        else
            send_word(mk_word(OPN_START, 0, OP_LOAD, 2'd0, 1'b0, 64'd0));
    endtask

    initial begin
        int lens [12] = '{0, 1, 256, 6, 511, 12, 3, 20, 9, 16, 40, 7};
        int phase, len, eff, steps;
        aresetn = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        s_valid = 0;
        s_data = '0;
        gap_pct = 0;
        stall_pct = 0;
        hold_tickets = 0;
        words_sent = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Idle machine: a step faults, an unknown operation is ignored,
        // and with no program a run halts immediately.
        send_word(mk_word(OPN_STEP, 0, OP_LOAD, 2'd0, 1'b0, 64'd0));
        send_word(mk_word(OPN_NONE, 255, OP_PRINT, 2'd3, 1'b1, '1));
        send_word(mk_word(OPN_START, 0, OP_LOAD, 2'd0, 1'b0, 64'd0));
        send_word(mk_word(OPN_STEP, 0, OP_LOAD, 2'd0, 1'b0, 64'd0));
        wait_drained();
        set_length(8);
        send_word(mk_word(OPN_LOAD, 0, OP_SET, RS_A, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF));
        send_word(mk_word(OPN_LOAD, 1, OP_ADD, RS_A, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF));
        send_word(mk_word(OPN_LOAD, 2, OP_STORE, RS_A, 1'b1, 64'h0000_03FF_8000_0000));
        send_word(mk_word(OPN_LOAD, 3, OP_SET, RS_B, 1'b1, 64'h8000_0000_0000_0000));
        send_word(mk_word(OPN_LOAD, 4, OP_SUB, RS_A, 1'b0, 64'd0));
        send_word(mk_word(OPN_LOAD, 5, OP_MUL, RS_B, 1'b1, 64'h0000_0002_0000_0000));
        send_word(mk_word(OPN_LOAD, 6, OP_PRINT, RS_B, 1'b1, 64'h0000_03FF_0000_0000));
        send_word(mk_word(OPN_LOAD, 7, OP_DIV, RS_A, 1'b1, 64'd0));
        send_word(mk_word(OPN_START, 0, OP_LOAD, 2'd0, 1'b0, 64'd0));
        repeat (9) send_word(mk_word(OPN_STEP, 0, OP_LOAD, 2'd0, 1'b0, 64'd0));

        phase = 0;
        while (words_sent < 640) begin
            wait_drained();
            case (phase % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 50; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 50; end
                default: begin gap_pct = 16; stall_pct = 16; end
            endcase
            len = (phase < 12) ? lens[phase] : $urandom_range(2, 24);
            eff = (len < PROG_DEPTH_DEF) ? len : PROG_DEPTH_DEF;
            set_length(len);
            // Every slot a run can reach must hold an instruction.
            for (int i = 0; i < eff; i++)
                if (!slot_loaded[i] || $urandom_range(2) == 0)
                    send_word(rand_instr(i, eff));
            for (int run = 0; run < 2; run++) begin
                send_word(mk_word(OPN_START, 0, OP_LOAD, 2'd0, 1'b0, 64'd0));
                if (phase % 4 == 2 && run == 0) hold_tickets++;
                steps = $urandom_range(eff + 2, 2 * eff + 6);
                if (steps > 40) steps = 40;
                for (int k = 0; k < steps; k++) begin
                    if ($urandom_range(19) == 0) noise_word(eff);
                    send_word(mk_word(OPN_STEP, $urandom_range(255),
                                      opcode_t'($urandom_range(15)), 2'($urandom_range(3)),
                                      1'($urandom_range(1)), {$urandom, $urandom}));
                end
            end
            phase++;
        end
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
